[sv/utf8n_pkg.sv]
// Shared types, constants and folding functions for the UTF-8 search normalizer.
// No dependencies; used by every module of the block.
package utf8n_pkg;

  localparam logic [7:0] LEAD_BYTE     = 8'hC3;
  localparam logic [7:0] CAPS_ADD      = 8'h20;
  localparam int         FIFO_DEPTH_DF = 4;

  // Number of bytes one input byte folds into
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } byte_cnt_t;

  // Work item passed from the front to the back
  typedef struct packed {
    byte_cnt_t  cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } op_t;

  // Characters removed from the folded text
  function automatic logic is_dropped(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
           (b == 8'h2E) || (b == 8'h2C) || (b == 8'h2D) || (b == 8'h5F);
  endfunction

  // Latin-1 capital range inside a lead pair
  function automatic logic is_pair_cap(input logic [7:0] n);
    return (n inside {[8'h80:8'h96], [8'h98:8'h9E]});
  endfunction

  // Plain letter for a lowered pair second byte; zero when unmatched
  function automatic logic [7:0] pair_letter(input logic [7:0] n);
    logic [7:0] r;
    r = 8'h00;
    if (n inside {[8'hA0:8'hA5], [8'h80:8'h85]})      r = "a";
    else if (n inside {[8'hA8:8'hAB], [8'h88:8'h8B]}) r = "e";
    else if (n inside {[8'hAC:8'hAF], [8'h8C:8'h8F]}) r = "i";
    else if (n inside {[8'hB2:8'hB6], [8'h92:8'h96]}) r = "o";
    else if (n inside {[8'hB9:8'hBC], [8'h99:8'h9C]}) r = "u";
    else if (n inside {8'hB1, 8'h91})                 r = "n";
    else if (n inside {8'hA7, 8'h87})                 r = "c";
    return r;
  endfunction

  // Single-byte Latin-1 fold
  function automatic logic [7:0] single_fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]})                     r = c + CAPS_ADD;
    else if (c inside {[8'hE0:8'hE5], [8'hC0:8'hC5]}) r = "a";
    else if (c inside {[8'hE8:8'hEB], [8'hC8:8'hCB]}) r = "e";
    else if (c inside {[8'hEC:8'hEF], [8'hCC:8'hCF]}) r = "i";
    else if (c inside {[8'hF2:8'hF6], [8'hD2:8'hD6]}) r = "o";
    else if (c inside {[8'hF9:8'hFC], [8'hD9:8'hDC]}) r = "u";
    else if (c inside {8'hF1, 8'hD1})                 r = "n";
    return r;
  endfunction

endpackage

[sv/utf8n_front.sv]
// Front end: accepts raw bytes, tracks the held 0xC3 lead and classifies each beat.
// Depends on utf8n_pkg; feeds utf8n_fifo.
module utf8n_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_string_last,
  input  logic            fifo_full,
  output logic            push,
  output utf8n_pkg::op_t  push_op,
  output logic            lead_held
);
  import utf8n_pkg::*;

  logic       lead_r, lead_nxt;
  logic       accept;
  logic       take_lead;
  logic [7:0] n_low;
  logic [7:0] rep;
  logic [7:0] sfold;
  op_t        op;

  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;
  assign lead_held = lead_r;

  // Classify the incoming byte
  always_comb begin
    n_low     = is_pair_cap(in_byte) ? in_byte + CAPS_ADD : in_byte;
    rep       = pair_letter(n_low);
    sfold     = single_fold(in_byte);
    take_lead = 1'b0;
    op.cnt    = CNT_NONE;
    op.b0     = 8'h00;
    op.b1     = 8'h00;
    op.last   = in_string_last;
    if (lead_r) begin
      if (rep != 8'h00) begin
        op.cnt = CNT_ONE;
        op.b0  = rep;
      end else begin
        op.b0  = LEAD_BYTE;
        op.b1  = n_low;
        op.cnt = is_dropped(n_low) ? CNT_ONE : CNT_TWO;
      end
    end else if (in_byte == LEAD_BYTE && !in_string_last) begin
      take_lead = 1'b1;
    end else if (!is_dropped(sfold)) begin
      op.cnt = CNT_ONE;
      op.b0  = sfold;
    end
  end

  assign push    = accept && ((op.cnt != CNT_NONE) || in_string_last);
  assign push_op = op;

  // Hold or clear the lead flag
  always_comb begin
    lead_nxt = lead_r;
    if (accept) lead_nxt = take_lead;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 1'b0;
    end else begin
      lead_r <= lead_nxt;
    end
  end

endmodule

[sv/utf8n_fifo.sv]
// Short queue of classified work items between the front and the back.
// Depends on utf8n_pkg for the item type.
module utf8n_fifo #(
  parameter int DEPTH = utf8n_pkg::FIFO_DEPTH_DF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8n_pkg::op_t  push_op,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output utf8n_pkg::op_t  head_op
);
  import utf8n_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule

[sv/utf8n_back.sv]
// Back end: expands queued items into one or two result beats in an output register.
// Depends on utf8n_pkg; drains utf8n_fifo.
module utf8n_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  utf8n_pkg::op_t  head_op,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_end,
  output logic            out_run_last
);
  import utf8n_pkg::*;

  logic       vld_r, vld_nxt;
  logic       second_r, second_nxt;
  logic [7:0] byte_r;
  logic       bval_r, end_r, run_r;
  logic       load;
  logic [7:0] beat_byte;
  logic       beat_bval, beat_final;

  assign load = (!vld_r || out_ready) && !empty;

  // Select the beat of the head item
  always_comb begin
    if (second_r) begin
      beat_byte  = head_op.b1;
      beat_bval  = 1'b1;
      beat_final = 1'b1;
    end else begin
      beat_byte  = head_op.b0;
      beat_bval  = (head_op.cnt != CNT_NONE);
      beat_final = (head_op.cnt != CNT_TWO);
    end
  end

  assign pop = load && beat_final;

  // Advance beat index and output valid
  always_comb begin
    second_nxt = second_r;
    vld_nxt    = vld_r;
    if (out_ready) vld_nxt = 1'b0;
    if (load) begin
      vld_nxt    = 1'b1;
      second_nxt = !beat_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      second_r <= second_nxt;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= beat_byte;
      bval_r <= beat_bval;
      end_r  <= beat_final && head_op.last;
      run_r  <= beat_final;
    end
  end

  assign out_valid      = vld_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bval_r;
  assign out_string_end = end_r;
  assign out_run_last   = run_r;

endmodule

[sv/utf8_text_search_normalizer.sv]
// Search-folding normalizer: lowercases ASCII, joins 0xC3 lead pairs, folds Latin-1
// accents to plain letters and drops blanks and punctuation. One input byte is taken
// per cycle while the item queue (FIFO_DEPTH entries) has room; each byte yields zero,
// one or two result beats, and the output register sends one beat per cycle while
// out_ready is high. Depends on utf8n_pkg, utf8n_front, utf8n_fifo, utf8n_back.
module utf8_text_search_normalizer #(
  parameter int FIFO_DEPTH = utf8n_pkg::FIFO_DEPTH_DF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_string_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_run_last
);
  import utf8n_pkg::*;

  logic push, pop, fifo_full, fifo_empty, lead_held;
  op_t  push_op, head_op;

  utf8n_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_string_last (in_string_last),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_op        (push_op),
    .lead_held      (lead_held)
  );

  utf8n_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (fifo_full),
    .empty   (fifo_empty),
    .head_op (head_op)
  );

  utf8n_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (fifo_empty),
    .head_op        (head_op),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_end (out_string_end),
    .out_run_last   (out_run_last)
  );

  // A bare end marker carries no byte and closes both the run and the string
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_string_end && out_run_last && out_byte == 8'h00)
    else $error("bare end marker malformed");

  // String end only on the last beat of a byte
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last)
    else $error("string end without run end");

  // A mid-string lead byte is held for the next beat
  a_lead_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_byte == LEAD_BYTE && !in_string_last && !lead_held
    |=> lead_held)
    else $error("lead byte not held");

  // A held lead produces no queue entry
  a_lead_nopush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_byte == LEAD_BYTE && !in_string_last && !lead_held
    |-> !push)
    else $error("held lead pushed an item");

  // No byte taken while the queue is full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !in_ready)
    else $error("input accepted into full queue");

endmodule

[bench/utf8_text_search_normalizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for utf8_text_search_normalizer: directed and random text strings
// with random idle on both channels. Depends on utf8n_pkg and the normalizer RTL.
module utf8_text_search_normalizer_tb;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 50;

  // Characters removed from folded text
  localparam logic [7:0] BLANK_SET [0:7] = '{8'h20, 8'h09, 8'h0D, 8'h0A,
                                             8'h2E, 8'h2C, 8'h2D, 8'h5F};

  // One output beat of folded text
  typedef struct packed {
    logic [7:0] ch;
    logic       has_byte;
    logic       str_end;
    logic       run_end;
  } fold_beat_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_byte        = 8'h00;
  logic       in_string_last = 1'b0;
  logic       out_ready      = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_string_end;
  logic       out_run_last;

  fold_beat_t fold_q[$];
  logic       lead_held      = 1'b0;
  logic       calm           = 1'b0;
  int         mismatch_count = 0;
  int         items_sent     = 0;
  int         cycle_count    = 0;
  int         stall_left     = 0;

  utf8_text_search_normalizer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_string_last (in_string_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_end (out_string_end),
    .out_run_last   (out_run_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    foreach (BLANK_SET[i]) if (c == BLANK_SET[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Plain letter for a lowered second byte of a lead pair, zero if none
  function automatic logic [7:0] pair_plain(input logic [7:0] n);
    logic [7:0] lo;
    lo = n & 8'hDF;  // both the 0x8x and 0xAx rows map alike
    if (n < 8'h80 || n > 8'hBF) return 8'h00;
    if (lo >= 8'h80 && lo <= 8'h85) return "a";
    if (lo >= 8'h88 && lo <= 8'h8B) return "e";
    if (lo >= 8'h8C && lo <= 8'h8F) return "i";
    if (lo >= 8'h92 && lo <= 8'h96) return "o";
    if (lo >= 8'h99 && lo <= 8'h9C) return "u";
    if (lo == 8'h91) return "n";
    if (lo == 8'h87) return "c";
    return 8'h00;
  endfunction

  // Fold of a byte outside any pair
  function automatic logic [7:0] latin1_fold(input logic [7:0] c);
    logic [7:0] lo;
    lo = c & 8'hDF;
    if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
    if (c < 8'hC0) return c;
    if (lo >= 8'hC0 && lo <= 8'hC5) return "a";
    if (lo >= 8'hC8 && lo <= 8'hCB) return "e";
    if (lo >= 8'hCC && lo <= 8'hCF) return "i";
    if (lo >= 8'hD2 && lo <= 8'hD6) return "o";
    if (lo >= 8'hD9 && lo <= 8'hDC) return "u";
    if (lo == 8'hD1) return "n";
    return c;
  endfunction

  // Work out the beats one accepted byte yields and queue them
  task automatic fold_input(input logic [7:0] b, input logic lst);
    logic [7:0] folded [0:1];
    logic [7:0] n;
    logic [7:0] plain;
    int         cnt;
    fold_beat_t beat;
    cnt = 0;
    if (lead_held) begin
      lead_held = 1'b0;
      n = b;
      if ((b >= 8'h80 && b <= 8'h96) || (b >= 8'h98 && b <= 8'h9E)) n = b + 8'h20;
      plain = pair_plain(n);
      if (plain != 8'h00) begin
        folded[cnt++] = plain;
      end else begin
        folded[cnt++] = utf8n_pkg::LEAD_BYTE;
        if (!is_blank(n)) folded[cnt++] = n;
      end
    end else if (b == utf8n_pkg::LEAD_BYTE && !lst) begin
      lead_held = 1'b1;
    end else begin
      plain = latin1_fold(b);
      if (!is_blank(plain)) folded[cnt++] = plain;
    end
    // bare end marker when everything was dropped on the last byte
    if (cnt == 0 && lst) begin
      beat = '{ch: 8'h00, has_byte: 1'b0, str_end: 1'b1, run_end: 1'b1};
      fold_q.push_back(beat);
    end
    for (int k = 0; k < cnt; k++) begin
      beat.ch       = folded[k];
      beat.has_byte = 1'b1;
      beat.run_end  = (k == cnt - 1);
      beat.str_end  = (k == cnt - 1) && lst;
      fold_q.push_back(beat);
    end
  endtask

  // Offer one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_string_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_input(b, lst);
    items_sent++;
  endtask

  // Drop valid and wait for every queued beat to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (fold_q.size() != 0);
  endtask

  // Build one string of mixed classes and send it
  task automatic send_random_string();
    logic [7:0] text_q[$];
    int         len;
    int         r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    while (text_q.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        text_q.push_back(utf8n_pkg::LEAD_BYTE);
        if ($urandom_range(0, 4) != 0) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 60) begin
        text_q.push_back(8'($urandom_range(8'h41, 8'h5A)) |
                         ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      end else if (r < 72) begin
        text_q.push_back(BLANK_SET[$urandom_range(0, 7)]);
      end else if (r < 80) begin
        text_q.push_back(utf8n_pkg::LEAD_BYTE);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Hold reset low, then release it
  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // ASCII range edges around A-Z
  task automatic test_ascii_case();
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Every dropped character; the string ends with nothing left
  task automatic test_dropped_chars();
    foreach (BLANK_SET[i]) send_byte(BLANK_SET[i], i == 7);
  endtask

  // Capital pair, unmatched pair, ASCII second byte, dropped second byte at string end
  task automatic test_lead_pairs();
    send_byte(utf8n_pkg::LEAD_BYTE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(utf8n_pkg::LEAD_BYTE, 1'b0);
    send_byte(8'h9E, 1'b0);
    send_byte(utf8n_pkg::LEAD_BYTE, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(utf8n_pkg::LEAD_BYTE, 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  // Lone lead at string end and single-byte Latin-1 folds
  task automatic test_lone_lead_latin1();
    send_byte(utf8n_pkg::LEAD_BYTE, 1'b1);
    send_byte(8'hE5, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_text(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) send_random_string();
  endtask

  // Pause the sender until the output has fully drained, several times over
  task automatic test_drain_pause();
    repeat (6) begin
      send_random_string();
      wait_drained();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_calm_stretch(input int n);
    calm = 1'b1;
    test_random_text(n);
    calm = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input fold_beat_t got,
                                 input fold_beat_t want);
    if (mismatch_count < PRINT_CAP)
      $display("%0d: %s: got byte=%02h bv=%b end=%b run=%b want byte=%02h bv=%b end=%b run=%b",
               cycle_count, what, got.ch, got.has_byte, got.str_end, got.run_end,
               want.ch, want.has_byte, want.str_end, want.run_end);
    mismatch_count++;
  endtask

  // Random stalls on the result side
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    fold_beat_t got;
    fold_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{ch: out_byte, has_byte: out_byte_valid, str_end: out_string_end,
              run_end: out_run_last};
      if (fold_q.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = fold_q.pop_front();
        if (got.ch !== want.ch || got.has_byte !== want.has_byte ||
            got.str_end !== want.str_end || got.run_end !== want.run_end)
          report_mismatch("beat mismatch", got, want);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    apply_reset();
    test_ascii_case();
    test_dropped_chars();
    test_lead_pairs();
    test_lone_lead_latin1();
    test_random_text(400);
    test_drain_pause();
    test_calm_stretch(150);
    test_random_text(450);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
